FILE: rtl/nonpreemptive_priority_scheduler_defines.svh
// assertion macros of the scheduler checker
// no dependencies; included by nps_checker, which holds concurrent assertions
`ifndef NONPREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH
`define NONPREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define NPS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// next-cycle implication, disabled during reset
`define NPS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

FILE: rtl/nps_pkg.sv
// shared types and constants of the priority scheduler
// no dependencies; used by the queue memory, the top level and the checker
package nps_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int ID_W    = 4;
    localparam int PRIO_W  = 4;
    localparam int BURST_W = 16;
    localparam int TIME_W  = 32;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 72;

    localparam logic ACTION_ARRIVE = 1'b0;
    localparam logic ACTION_TICK   = 1'b1;

    localparam logic KIND_DISPATCH = 1'b0;
    localparam logic KIND_REJECT   = 1'b1;

    typedef struct packed {
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic [ID_W-1:0]    id;
    } queue_entry_t;

endpackage

FILE: rtl/nps_queue_ram.sv
// ready queue storage: one write port, one read port with registered data
// depends on nps_pkg for the entry type
module nps_queue_ram
    import nps_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int IW    = $clog2(QUEUE_DEPTH_DEF)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_addr,
    input  queue_entry_t  wr_data,
    input  logic [IW-1:0] rd_addr,
    output queue_entry_t  rd_data
);

    queue_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/nonpreemptive_priority_scheduler.sv
// Non-preemptive priority scheduler. Arrive items append a job {id, priority,
// burst} to a ready queue held in a single-port-read memory; a full queue
// rejects the job with a result of kind reject. Tick items advance time by one;
// when the running job has reached its finish time and the queue holds n jobs,
// the queue is scanned for the smallest priority number (latest entry wins
// ties), the chosen entry is removed by shifting the later entries down, and a
// dispatch result carries start and finish time. A new item is taken only in
// the idle state, so the block finishes each item before it takes the next. A
// finished result waits in the output register while the next item is taken.
// depends on nps_pkg and nps_queue_ram
module nonpreemptive_priority_scheduler
    import nps_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // job_id, job_priority, job_burst
    input  logic                  s_tuser,   // action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // out_job_id, start_time, finish_time, zero pad
    output logic                  m_tuser    // kind
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_SHIFT, ST_EMIT} state_t;

    state_t              state_reg;
    logic [CW-1:0]       count_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [TIME_W-1:0]   busy_until_reg;
    logic                busy_reg;
    logic [IW-1:0]       cmp_idx_reg;
    logic [CW-1:0]       src_reg;
    logic [IW-1:0]       dst_reg;
    logic                wr_vld_reg;
    logic                m_tvalid_reg;

    logic [IW-1:0]       best_pos_reg;
    logic [PRIO_W-1:0]   best_prio_reg;
    logic [ID_W-1:0]     best_id_reg;
    logic [BURST_W-1:0]  best_burst_reg;
    logic                res_kind_reg;
    logic [ID_W-1:0]     res_id_reg;
    logic [TIME_W-1:0]   res_finish_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                m_tuser_reg;

    logic [ID_W-1:0]     in_id;
    logic [PRIO_W-1:0]   in_prio;
    logic [BURST_W-1:0]  in_burst;
    logic                accept;
    logic                queue_full;
    logic                busy_next;
    logic                take;
    logic                scan_last;
    logic                out_free;
    logic [IW-1:0]       best_pos_sel;

    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    queue_entry_t        wr_data;
    logic [IW-1:0]       rd_addr;
    queue_entry_t        rd_data;

    assign in_id    = s_tdata[3:0];
    assign in_prio  = s_tdata[7:4];
    assign in_burst = s_tdata[23:8];

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign queue_full = (count_reg == CW'(QUEUE_DEPTH));
    assign busy_next  = busy_reg && (time_reg != busy_until_reg);
    assign out_free   = !m_tvalid_reg || m_tready;

    // first entry is always taken; later ones win on equal priority
    assign take         = (cmp_idx_reg == '0) || (rd_data.prio <= best_prio_reg);
    assign scan_last    = (CW'(cmp_idx_reg) == (count_reg - CW'(1)));
    assign best_pos_sel = take ? cmp_idx_reg : best_pos_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = count_reg[IW-1:0];
        wr_data = rd_data;
        rd_addr = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && s_tuser == ACTION_ARRIVE && !queue_full)
                begin
                    wr_en         = 1'b1;
                    wr_data.id    = in_id;
                    wr_data.prio  = in_prio;
                    wr_data.burst = (in_burst == '0) ? BURST_W'(1) : in_burst;
                end
            end
            ST_SCAN:
            begin
                rd_addr = cmp_idx_reg + IW'(1);
            end
            ST_SHIFT:
            begin
                rd_addr = src_reg[IW-1:0];
                wr_en   = wr_vld_reg;
                wr_addr = dst_reg;
            end
            ST_EMIT:
            begin
                rd_addr = '0;
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    nps_queue_ram #(
        .DEPTH (QUEUE_DEPTH),
        .IW    (IW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            time_reg       <= '0;
            busy_until_reg <= '0;
            busy_reg       <= 1'b0;
            cmp_idx_reg    <= '0;
            src_reg        <= '0;
            dst_reg        <= '0;
            wr_vld_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_EMIT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (s_tuser == ACTION_ARRIVE)
                        begin
                            if (queue_full)
                            begin
                                state_reg <= ST_EMIT;
                            end
                            else
                            begin
                                count_reg <= count_reg + CW'(1);
                            end
                        end
                        else if (!busy_next && count_reg != '0)
                        begin
                            // entry 0 is being read this cycle
                            busy_reg    <= 1'b0;
                            cmp_idx_reg <= '0;
                            state_reg   <= ST_SCAN;
                        end
                        else
                        begin
                            busy_reg <= busy_next;
                            time_reg <= time_reg + TIME_W'(1);
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (scan_last)
                    begin
                        src_reg    <= CW'(best_pos_sel) + CW'(1);
                        wr_vld_reg <= 1'b0;
                        state_reg  <= ST_SHIFT;
                    end
                    else
                    begin
                        cmp_idx_reg <= cmp_idx_reg + IW'(1);
                    end
                end
                ST_SHIFT:
                begin
                    // read src, write it back one place lower in the next cycle
                    if (src_reg < count_reg)
                    begin
                        wr_vld_reg <= 1'b1;
                        dst_reg    <= src_reg[IW-1:0] - IW'(1);
                        src_reg    <= src_reg + CW'(1);
                    end
                    else
                    begin
                        wr_vld_reg <= 1'b0;
                        count_reg  <= count_reg - CW'(1);
                        state_reg  <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                        if (res_kind_reg == KIND_DISPATCH)
                        begin
                            busy_reg       <= 1'b1;
                            busy_until_reg <= res_finish_reg;
                            time_reg       <= time_reg + TIME_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept)
        begin
            res_kind_reg <= (s_tuser == ACTION_ARRIVE) ? KIND_REJECT : KIND_DISPATCH;
            res_id_reg   <= in_id;
        end
        if (state_reg == ST_SCAN && take)
        begin
            best_pos_reg   <= cmp_idx_reg;
            best_prio_reg  <= rd_data.prio;
            best_id_reg    <= rd_data.id;
            best_burst_reg <= rd_data.burst;
        end
        if (state_reg == ST_SHIFT)
        begin
            res_id_reg     <= best_id_reg;
            res_finish_reg <= time_reg + TIME_W'(best_burst_reg);
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            m_tuser_reg <= res_kind_reg;
            if (res_kind_reg == KIND_DISPATCH)
            begin
                m_tdata_reg <= {4'b0000, res_finish_reg, time_reg, res_id_reg};
            end
            else
            begin
                m_tdata_reg <= {4'b0000, TIME_W'(0), TIME_W'(0), res_id_reg};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: rtl/nps_checker.sv
// port-level checks of the priority scheduler, bound to the top level
// depends on nps_pkg and the assertion macros header
`include "nonpreemptive_priority_scheduler_defines.svh"

module nps_checker
    import nps_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,   // out_job_id, start_time, finish_time, zero pad
    input logic                  m_tuser    // kind
);

    // a stalled result stays offered
    `NPS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)

    // rejects carry zero times
    `NPS_ASSERT_SAME(a_reject_zero, clk, rst_n, m_tvalid && m_tuser == KIND_REJECT,
        m_tdata[67:4] == 64'd0)

    // every burst is at least one tick
    `NPS_ASSERT_SAME(a_dispatch_len, clk, rst_n, m_tvalid && m_tuser == KIND_DISPATCH,
        m_tdata[67:36] != m_tdata[35:4])

    // a fresh result only follows a cycle in which no item was taken
    `NPS_ASSERT_SAME(a_result_after_work, clk, rst_n, $rose(m_tvalid), !$past(s_tready))

    // upper pad bits stay zero on every result
    `NPS_ASSERT_SAME(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[71:68] == 4'd0)

endmodule

bind nonpreemptive_priority_scheduler nps_checker u_nps_checker (.*);

FILE: dv/nonpreemptive_priority_scheduler_tb.sv
// self-checking testbench for the non-preemptive priority scheduler
// drives arrive and tick items, predicts dispatches and rejects, checks the result stream
// depends on nps_pkg and the scheduler rtl
module nonpreemptive_priority_scheduler_tb;
    import nps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 600;
    localparam int TAIL_ITEMS = 80;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int HOLD_AFTER_RESULTS = 25;

    typedef struct {
        logic               action;
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
        bit                 sync;     // hold this item until every result is back
    } job_item_t;

    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] finish;
    } decision_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // job_id, job_priority, job_burst
    logic                  s_tuser;   // action
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // out_job_id, start_time, finish_time, zero pad
    logic                  m_tuser;   // kind

    job_item_t job_stream[$];
    decision_t due_decisions[$];

    // scheduler state as the predictor sees it
    logic [ID_W-1:0]    ready_id[DEPTH];
    logic [PRIO_W-1:0]  ready_prio[DEPTH];
    logic [BURST_W-1:0] ready_burst[DEPTH];
    int                 ready_jobs;
    logic [TIME_W-1:0]  now_time;
    logic [TIME_W-1:0]  run_end;
    bit                 running;

    // driver side
    job_item_t cur_job;
    int        src_gap;
    int        predicted_total;
    bit        launch;
    bit        tail_phase;

    // receiver side
    int        results_seen;
    int        snk_gap;
    int        hold_left;
    bit        hold_done;
    bit        rdy;
    decision_t got;
    decision_t want;
    int        mismatches;

    nonpreemptive_priority_scheduler uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // applies one item to the predicted state, returns the number of results it causes
    function automatic int schedule_item(input job_item_t it);
        int        pick;
        int        produced;
        decision_t d;
        logic [BURST_W-1:0] b;
        produced = 0;
        if (it.action == ACTION_ARRIVE)
        begin
            if (ready_jobs >= DEPTH)
            begin
                d.kind = KIND_REJECT;
                d.id = it.id;
                d.start = '0;
                d.finish = '0;
                due_decisions.push_back(d);
                return 1;
            end
            b = (it.burst == '0) ? BURST_W'(1) : it.burst;
            ready_id[ready_jobs] = it.id;
            ready_prio[ready_jobs] = it.prio;
            ready_burst[ready_jobs] = b;
            ready_jobs++;
            return 0;
        end
        if (running && now_time == run_end)
            running = 1'b0;
        if (!running && ready_jobs > 0)
        begin
            // lowest priority number, latest entry on a tie
            pick = 0;
            for (int i = 1; i < ready_jobs; i++)
                if (ready_prio[i] <= ready_prio[pick])
                    pick = i;
            d.kind = KIND_DISPATCH;
            d.id = ready_id[pick];
            d.start = now_time;
            d.finish = now_time + TIME_W'(ready_burst[pick]);
            for (int i = pick; i + 1 < ready_jobs; i++)
            begin
                ready_id[i] = ready_id[i + 1];
                ready_prio[i] = ready_prio[i + 1];
                ready_burst[i] = ready_burst[i + 1];
            end
            ready_jobs--;
            run_end = d.finish;
            running = 1'b1;
            due_decisions.push_back(d);
            produced = 1;
        end
        now_time = now_time + 1;
        return produced;
    endfunction

    function automatic void add_arrive(input int id, input int prio, input int burst,
                                       input bit sync);
        job_item_t it;
        it.action = ACTION_ARRIVE;
        it.id = ID_W'(id);
        it.prio = PRIO_W'(prio);
        it.burst = BURST_W'(burst);
        it.sync = sync;
        job_stream.push_back(it);
    endfunction

    function automatic void add_tick(input bit sync);
        job_item_t it;
        it.action = ACTION_TICK;
        it.id = ID_W'($urandom);
        it.prio = PRIO_W'($urandom);
        it.burst = BURST_W'($urandom);
        it.sync = sync;
        job_stream.push_back(it);
    endfunction

    function automatic void add_random_arrive(input bit sync);
        int prio;
        int burst;
        int pick;
        prio = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 10) : $urandom_range(0, 15);
        pick = $urandom_range(0, 99);
        if (pick < 88)
            burst = $urandom_range(1, 6);
        else if (pick < 97)
            burst = $urandom_range(7, 60);
        else if (pick < 99)
            burst = 0;
        else
            burst = $urandom_range(61, 300);
        add_arrive($urandom_range(0, 15), prio, burst, sync);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // driver: offers items from job_stream, predicts each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= ACTION_TICK;
            tail_phase <= 1'b0;
            src_gap = 0;
            predicted_total = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predicted_total += schedule_item(cur_job);
            if (!s_tvalid || s_tready)
            begin
                launch = 1'b0;
                if (src_gap > 0)
                    src_gap--;
                else if (job_stream.size() == 0)
                    launch = 1'b0;
                else if (job_stream[0].sync && predicted_total != results_seen)
                    launch = 1'b0;
                else
                begin
                    cur_job = job_stream.pop_front();
                    launch = 1'b1;
                    if (!tail_phase && $urandom_range(0, 5) == 0)
                        src_gap = $urandom_range(1, 18);
                end
                s_tvalid <= launch;
                if (launch)
                begin
                    s_tdata <= {cur_job.burst, cur_job.prio, cur_job.id};
                    s_tuser <= cur_job.action;
                end
            end
            tail_phase <= (job_stream.size() < TAIL_ITEMS);
        end
    end

    // monitor: checks each result against the oldest due decision, drives backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            results_seen <= 0;
            snk_gap = 0;
            hold_left = 0;
            hold_done = 1'b0;
            mismatches = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.kind = m_tuser;
                got.id = m_tdata[ID_W-1:0];
                got.start = m_tdata[ID_W +: TIME_W];
                got.finish = m_tdata[ID_W+TIME_W +: TIME_W];
                if (due_decisions.size() == 0)
                begin
                    $display("%0t unexpected result: kind %0d id %0d start %0d finish %0d",
                             $realtime, got.kind, got.id, got.start, got.finish);
                    mismatches++;
                end
                else
                begin
                    want = due_decisions.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t result mismatch: exp kind %0d id %0d start %0d finish %0d",
                                 $realtime, want.kind, want.id, want.start, want.finish);
                        $display("%0t                  got kind %0d id %0d start %0d finish %0d",
                                 $realtime, got.kind, got.id, got.start, got.finish);
                        mismatches++;
                    end
                end
                results_seen <= results_seen + 1;
            end
            // one long stall so the block fills up and pushes back on its input
            if (!hold_done && results_seen == HOLD_AFTER_RESULTS)
            begin
                hold_left = LONG_HOLD_CYCLES;
                hold_done = 1'b1;
            end
            rdy = 1'b0;
            if (hold_left > 0)
                hold_left--;
            else if (snk_gap > 0)
                snk_gap--;
            else
            begin
                rdy = 1'b1;
                if (!tail_phase && $urandom_range(0, 7) == 0)
                    snk_gap = $urandom_range(1, 18);
            end
            m_tready <= rdy;
        end
    end

    initial
    begin
        int mode;
        int seg_len;
        int made;
        rst_n = 1'b0;
        ready_jobs = 0;
        now_time = '0;
        run_end = '0;
        running = 1'b0;

        // directed: empty tick, zero burst, priority tie, priority above ten, full queue
        add_tick(1'b0);
        add_arrive(0, 0, 0, 1'b0);
        add_tick(1'b0);
        add_arrive(3, 5, 2, 1'b0);
        add_arrive(4, 5, 3, 1'b0);
        add_arrive(5, 11, 1, 1'b0);
        add_arrive(15, 15, 1, 1'b0);
        repeat (4) add_tick(1'b0);
        for (int i = 0; i < 14; i++)
            add_arrive(i + 1, (i * 7) % 16, (i % 4) + 1, 1'b0);
        add_arrive(15, 15, 16'hFFFF, 1'b0);
        add_arrive(10, 0, 16'hAAAA, 1'b0);

        // random: flood, drain and mixed stretches
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            mode = $urandom_range(0, 2);
            seg_len = $urandom_range(10, 40);
            for (int i = 0; i < seg_len && made < RANDOM_ITEMS; i++)
            begin
                // pause the sender until everything is back, at the start and midway
                if ((made == 0 || made == RANDOM_ITEMS / 2 ||
                     ($urandom_range(0, 5) < 2 && mode == 0)) ||
                    (mode == 1 && $urandom_range(0, 99) < 85) ||
                    (mode == 2 && $urandom_range(0, 1) == 1))
                begin
                    if (made == 0 || made == RANDOM_ITEMS / 2)
                        add_tick(1'b1);
                    else
                        add_tick(1'b0);
                end
                else
                    add_random_arrive(1'b0);
                made++;
            end
        end

        // longest burst on the highest-ranked job, then let it dispatch
        add_arrive(9, 0, 16'hFFFF, 1'b1);
        repeat (40) add_tick(1'b0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (job_stream.size() != 0 || s_tvalid)
            @(negedge clk);
        while (due_decisions.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        if (mismatches == 0 && due_decisions.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/nps_pkg.sv
rtl/nps_queue_ram.sv
rtl/nonpreemptive_priority_scheduler.sv
rtl/nps_checker.sv
dv/nonpreemptive_priority_scheduler_tb.sv
